// File: sv/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types, register indexes and reset values for the heading PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpid_pkg;

	// Configuration port geometry.
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 24;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DEADBAND       = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SAMPLE_RATE    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_HALF_PERIOD    = 3'd6;

	// Register reset values.
	localparam logic [23:0] RST_PROP_GAIN      = 24'd6554;
	localparam logic [23:0] RST_INTEG_GAIN     = 24'd66;
	localparam logic [23:0] RST_DERIV_GAIN     = 24'd524;
	localparam logic [22:0] RST_INTEGRAL_LIMIT = 23'd40960;
	localparam logic [14:0] RST_DEADBAND       = 15'd107;
	localparam logic [9:0]  RST_SAMPLE_RATE    = 10'd30;
	localparam logic [15:0] RST_HALF_PERIOD    = 16'd1092;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISTEP,
		ST_INTEG,
		ST_DRATE,
		ST_DGAIN,
		ST_DACC,
		ST_IACC,
		ST_FINISH
	} state_t;

	// Operand pairs of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_INTEG_STEP,
		MUL_PROP,
		MUL_RATE,
		MUL_DERIV,
		MUL_INTEG_GAIN
	} mul_sel_t;

	// Accumulator operations.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     integ_upd;
		logic     out_load;
	} cmd_t;

endpackage

`default_nettype wire

// File: sv/heading_pid_with_deadband.sv
// ----------------------------------------------------------------------------
// heading_pid_with_deadband
// Fixed-point heading PID with deadband, trapezoidal integral and clamp.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   input     in_valid / in_ready    measured_angle, reference_angle,
//                                    stop_request
//   output    out_valid / out_ready  drive
//   config    cfg_we                 cfg_index, cfg_wdata
//
// The output register is loaded in FINISH, after the states ISTEP, INTEG, DRATE,
// DGAIN, DACC and IACC that form the five products on one shared 25x28 multiplier.
// The next sample is taken in the cycle after the output register is loaded.
// A stalled output beat holds the last step until the result register frees.
// Reset clears the integral and the previous error and restores the
// register defaults; there is no clearing pass.
//
`default_nettype none

module heading_pid_with_deadband (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [hpid_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hpid_pkg::CfgDataW-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [15:0]            measured_angle,
	input  wire logic signed [15:0]            reference_angle,
	input  wire logic                          stop_request,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 drive
);

	hpid_pkg::cmd_t cmd;

	// Sequencer.
	hpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	hpid_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.measured_angle  (measured_angle),
		.reference_angle (reference_angle),
		.stop_request    (stop_request),
		.cmd             (cmd),
		.drive           (drive)
	);

endmodule

`default_nettype wire

// File: sv/hpid_ctrl.sv
// ----------------------------------------------------------------------------
// hpid_ctrl
// Sequencer for one sample: drives the shared multiplier, the accumulator and
// the integral update, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output hpid_pkg::cmd_t     cmd
);

	hpid_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             can_load;

	// The output register may be refilled when empty or drained this cycle.
	assign can_load = !out_valid_q || out_ready;

	// State register and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hpid_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hpid_pkg::ST_IDLE:   if (in_valid) state_d = hpid_pkg::ST_ISTEP;
			hpid_pkg::ST_ISTEP:  state_d = hpid_pkg::ST_INTEG;
			hpid_pkg::ST_INTEG:  state_d = hpid_pkg::ST_DRATE;
			hpid_pkg::ST_DRATE:  state_d = hpid_pkg::ST_DGAIN;
			hpid_pkg::ST_DGAIN:  state_d = hpid_pkg::ST_DACC;
			hpid_pkg::ST_DACC:   state_d = hpid_pkg::ST_IACC;
			hpid_pkg::ST_IACC:   state_d = hpid_pkg::ST_FINISH;
			hpid_pkg::ST_FINISH: if (can_load) state_d = hpid_pkg::ST_IDLE;
			default:             state_d = hpid_pkg::ST_IDLE;
		endcase
	end

	// Commands per state.
	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = hpid_pkg::MUL_PROP;
		cmd.acc_op    = hpid_pkg::ACC_HOLD;
		in_ready      = 1'b0;
		unique case (state_q)
			hpid_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			hpid_pkg::ST_ISTEP: begin
				cmd.mul_sel = hpid_pkg::MUL_INTEG_STEP;
			end
			hpid_pkg::ST_INTEG: begin
				cmd.integ_upd = 1'b1;
				cmd.mul_sel   = hpid_pkg::MUL_PROP;
			end
			hpid_pkg::ST_DRATE: begin
				cmd.acc_op  = hpid_pkg::ACC_LOAD;
				cmd.mul_sel = hpid_pkg::MUL_RATE;
			end
			hpid_pkg::ST_DGAIN: begin
				cmd.mul_sel = hpid_pkg::MUL_DERIV;
			end
			hpid_pkg::ST_DACC: begin
				cmd.acc_op  = hpid_pkg::ACC_ADD;
				cmd.mul_sel = hpid_pkg::MUL_INTEG_GAIN;
			end
			hpid_pkg::ST_IACC: begin
				cmd.acc_op = hpid_pkg::ACC_ADD;
			end
			hpid_pkg::ST_FINISH: begin
				cmd.out_load = can_load;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/hpid_datapath.sv
// ----------------------------------------------------------------------------
// hpid_datapath
// Configuration registers, error and deadband logic, shared 25x28 multiplier,
// integral with clamp, drive accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hpid_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [hpid_pkg::CfgDataW-1:0]     cfg_wdata,
	input  wire logic signed [15:0]                measured_angle,
	input  wire logic signed [15:0]                reference_angle,
	input  wire logic                              stop_request,
	input  wire hpid_pkg::cmd_t                    cmd,
	output logic signed [31:0]                     drive
);

	// Configuration registers.
	logic [23:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [22:0] integral_limit_q;
	logic [14:0] deadband_q;
	logic [9:0]  sample_rate_q;
	logic [15:0] half_period_q;

	// Loop state.
	logic signed [23:0] integral_q;
	logic signed [15:0] prev_err_q;

	// Per-sample working registers.
	logic signed [15:0] err_q;
	logic signed [16:0] diff_q;
	logic signed [16:0] esum_q;
	logic               stop_q;
	logic signed [52:0] mul_q;
	logic signed [54:0] acc_q;
	logic signed [31:0] drive_q;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= hpid_pkg::RST_PROP_GAIN;
			integ_gain_q     <= hpid_pkg::RST_INTEG_GAIN;
			deriv_gain_q     <= hpid_pkg::RST_DERIV_GAIN;
			integral_limit_q <= hpid_pkg::RST_INTEGRAL_LIMIT;
			deadband_q       <= hpid_pkg::RST_DEADBAND;
			sample_rate_q    <= hpid_pkg::RST_SAMPLE_RATE;
			half_period_q    <= hpid_pkg::RST_HALF_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpid_pkg::REG_PROP_GAIN:      prop_gain_q      <= cfg_wdata;
				hpid_pkg::REG_INTEG_GAIN:     integ_gain_q     <= cfg_wdata;
				hpid_pkg::REG_DERIV_GAIN:     deriv_gain_q     <= cfg_wdata;
				hpid_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata[22:0];
				hpid_pkg::REG_DEADBAND:       deadband_q       <= cfg_wdata[14:0];
				hpid_pkg::REG_SAMPLE_RATE:    sample_rate_q    <= cfg_wdata[9:0];
				hpid_pkg::REG_HALF_PERIOD:    half_period_q    <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Error: saturated difference, then zeroed inside the deadband.
	logic signed [16:0] err_raw;
	logic signed [15:0] err_sat;
	logic        [16:0] err_mag;
	logic signed [15:0] err_db;

	always_comb begin
		err_raw = {reference_angle[15], reference_angle} - {measured_angle[15], measured_angle};
		if (err_raw[16] != err_raw[15]) begin
			err_sat = err_raw[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			err_sat = err_raw[15:0];
		end
		err_mag = err_sat[15] ? (17'd0 - {1'b1, err_sat}) : {1'b0, err_sat};
		err_db  = (err_mag < {2'b00, deadband_q}) ? 16'sd0 : err_sat;
	end

	// Sample capture at the input beat.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			err_q  <= err_db;
			diff_q <= {err_db[15], err_db} - {prev_err_q[15], prev_err_q};
			esum_q <= {err_db[15], err_db} + {prev_err_q[15], prev_err_q};
			stop_q <= stop_request;
		end
	end

	// Shared multiplier with registered product.
	logic signed [24:0] mul_a;
	logic signed [27:0] mul_b;

	always_comb begin
		unique case (cmd.mul_sel)
			hpid_pkg::MUL_INTEG_STEP: begin
				mul_a = {9'd0, half_period_q};
				mul_b = {{11{esum_q[16]}}, esum_q};
			end
			hpid_pkg::MUL_PROP: begin
				mul_a = {1'b0, prop_gain_q};
				mul_b = {{12{err_q[15]}}, err_q};
			end
			hpid_pkg::MUL_RATE: begin
				mul_a = {15'd0, sample_rate_q};
				mul_b = {{11{diff_q[16]}}, diff_q};
			end
			hpid_pkg::MUL_DERIV: begin
				mul_a = {1'b0, deriv_gain_q};
				mul_b = mul_q[27:0];
			end
			hpid_pkg::MUL_INTEG_GAIN: begin
				mul_a = {1'b0, integ_gain_q};
				mul_b = {{4{integral_q[23]}}, integral_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Integral step: round the product to Q.12, add, clamp, then apply stop.
	logic signed [34:0] step_rnd;
	logic signed [18:0] step_q12;
	logic signed [25:0] integ_sum;
	logic signed [25:0] integ_lim;
	logic signed [23:0] integ_next;

	always_comb begin
		step_rnd  = $signed(mul_q[34:0]) + 35'sd32768;
		step_q12  = step_rnd[34:16];
		integ_sum = {{2{integral_q[23]}}, integral_q} + {{7{step_q12[18]}}, step_q12};
		integ_lim = {3'b000, integral_limit_q};
		priority if (stop_q) begin
			integ_next = 24'sd0;
		end else if (integ_sum > integ_lim) begin
			integ_next = integ_lim[23:0];
		end else if (integ_sum < -integ_lim) begin
			integ_next = 24'(-integ_lim);
		end else begin
			integ_next = integ_sum[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (cmd.integ_upd) begin
			integral_q <= integ_next;
			prev_err_q <= err_q;
		end
	end

	// Drive accumulator at Q.28.
	logic signed [54:0] mul_ext;
	assign mul_ext = {{2{mul_q[52]}}, mul_q};

	always_ff @(posedge clk) begin
		unique case (cmd.acc_op)
			hpid_pkg::ACC_LOAD: acc_q <= mul_ext;
			hpid_pkg::ACC_ADD:  acc_q <= acc_q + mul_ext;
			default:            acc_q <= acc_q;
		endcase
	end

	// Round to Q.16 and saturate to 32 bits.
	logic signed [54:0] acc_rnd;
	logic signed [42:0] acc_q16;
	logic signed [31:0] drive_sat;

	always_comb begin
		acc_rnd = acc_q + 55'sd2048;
		acc_q16 = acc_rnd[54:12];
		if (acc_q16[42:31] == {12{acc_q16[42]}}) begin
			drive_sat = acc_q16[31:0];
		end else begin
			drive_sat = acc_q16[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drive_q <= drive_sat;
		end
	end

	assign drive = drive_q;

endmodule

`default_nettype wire

// File: sv/hpid_checker.sv
// ----------------------------------------------------------------------------
// hpid_checker
// Port-level checks on the heading PID block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] drive
);

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat withdrawn while stalled");

	// A stalled output beat keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive))
		else $error("drive changed while stalled");

	// After an input beat in_ready must be low at the first step and at FINISH.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##6 !in_ready)
		else $error("input accepted during a sample");

	// A fresh result coincides with the return to idle.
	a_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while still busy");

endmodule

bind heading_pid_with_deadband hpid_checker u_hpid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive)
);

`default_nettype wire
